// ===== src/ksm_pkg.sv =====
// Shared types and constants for the scalar Kalman smoother.
// Used by ksm_ctrl, ksm_dp and the top level; depends on nothing.
package ksm_pkg;

    // Fixed-point layout: estimate and covariance are Q16.16, gain is Q1.16 (17 bits).
    localparam int FRAC_W     = 16;
    localparam int COV_W      = 32;
    localparam int NOISE_W    = 24;
    localparam int GAIN_W     = FRAC_W + 1;
    localparam int DIV_CNT_W  = $clog2(GAIN_W);
    localparam int DENOM_W    = COV_W + 1;
    localparam int REM_W      = DENOM_W + 1;
    localparam int PROD_W     = GAIN_W + COV_W;
    localparam int CH_W       = 2;
    localparam int OUT_W      = 16;
    localparam int MEAS_IN_W  = 16;

    localparam logic [GAIN_W-1:0]  GAIN_ONE = GAIN_W'(1) << FRAC_W;

    // Register map: paddr[2] selects the register.
    localparam int PADDR_W = 3;
    localparam logic REG_IDX_PROCESS_NOISE = 1'b0;
    localparam logic REG_IDX_MEASURE_NOISE = 1'b1;

    localparam logic [NOISE_W-1:0] PROCESS_NOISE_RST = 24'd1180;
    localparam logic [NOISE_W-1:0] MEASURE_NOISE_RST = 24'd32768;

    // Commands from the sequencer to the datapath.
    typedef struct packed {
        logic load;
        logic prep;
        logic dinit;
        logic div_step;
        logic mul_gain;
        logic mul_cov;
        logic commit;
        logic out_load;
    } ksm_cmd_t;

    // Status from the datapath to the sequencer.
    typedef struct packed {
        logic div_last;
    } ksm_status_t;

endpackage

// ===== src/ksm_ctrl.sv =====
// Sequencer for the scalar Kalman smoother: steps one sample through
// prepare, divide, multiply and commit. Depends on ksm_pkg.
module ksm_ctrl #(
    parameter int CHANNELS = 3
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [ksm_pkg::CH_W-1:0]       s_tuser,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output ksm_pkg::ksm_cmd_t              cmd,
    input  ksm_pkg::ksm_status_t           status
);
    import ksm_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PREP,
        ST_DINIT,
        ST_DIV,
        ST_MUL1,
        ST_MUL2,
        ST_FIN
    } state_t;

    state_t state_reg, state_next;
    logic   m_tvalid_reg, m_tvalid_next;
    logic   in_range;
    logic   out_free;

    assign in_range = int'(s_tuser) < CHANNELS;
    assign out_free = !m_tvalid_reg || m_tready;
    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;

    // Decode commands from the current state
    always_comb begin
        cmd          = '0;
        cmd.load     = (state_reg == ST_IDLE) && s_tvalid;
        cmd.prep     = (state_reg == ST_PREP);
        cmd.dinit    = (state_reg == ST_DINIT);
        cmd.div_step = (state_reg == ST_DIV);
        cmd.mul_gain = (state_reg == ST_MUL1);
        cmd.mul_cov  = (state_reg == ST_MUL2);
        cmd.commit   = (state_reg == ST_FIN);
        cmd.out_load = (state_reg == ST_FIN) && out_free;
    end

    // Next state and output valid
    always_comb begin
        state_next    = state_reg;
        m_tvalid_next = m_tvalid_reg;
        if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid && in_range) begin
                    state_next = ST_PREP;
                end
            end
            ST_PREP:  state_next = ST_DINIT;
            ST_DINIT: state_next = ST_DIV;
            ST_DIV: begin
                if (status.div_last) begin
                    state_next = ST_MUL1;
                end
            end
            ST_MUL1:  state_next = ST_MUL2;
            ST_MUL2:  state_next = ST_FIN;
            ST_FIN: begin
                // Hold the result until the output register frees up
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default:  state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

endmodule

// ===== src/ksm_dp.sv =====
// Datapath for the scalar Kalman smoother: per-channel state, the
// restoring gain divider, the shared multiplier and the output register. Depends on ksm_pkg.
module ksm_dp #(
    parameter int CHANNELS     = 3,
    parameter int SAMPLE_WIDTH = 16
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  ksm_pkg::ksm_cmd_t                 cmd,
    output ksm_pkg::ksm_status_t              status,
    input  logic [ksm_pkg::CH_W-1:0]          s_tuser,
    input  logic [ksm_pkg::MEAS_IN_W-1:0]     s_meas,
    input  logic [ksm_pkg::NOISE_W-1:0]       process_noise,
    input  logic [ksm_pkg::NOISE_W-1:0]       measure_noise,
    output logic [ksm_pkg::CH_W-1:0]          m_tuser,
    output logic [ksm_pkg::OUT_W-1:0]         m_filtered
);
    import ksm_pkg::*;

    localparam int MEAS_W = (SAMPLE_WIDTH < MEAS_IN_W) ? SAMPLE_WIDTH : MEAS_IN_W;
    localparam int EST_W  = MEAS_W + FRAC_W;

    // Per-channel state
    logic [EST_W-1:0]    est_mem_reg [CHANNELS];
    logic [COV_W-1:0]    cov_mem_reg [CHANNELS];
    logic [CHANNELS-1:0] started_reg;

    // Working registers
    logic [CH_W-1:0]      ch_reg;
    logic [MEAS_W-1:0]    meas_reg;
    logic [EST_W-1:0]     est_reg;
    logic [COV_W-1:0]     pred_reg;
    logic [DENOM_W-1:0]   denom_reg;
    logic [REM_W-1:0]     rem_reg;
    logic [GAIN_W-1:0]    quo_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic                 ge_reg;
    logic [EST_W-1:0]     diff_reg;
    logic [PROD_W-1:0]    prod_reg;
    logic [CH_W-1:0]      out_ch_reg;
    logic [OUT_W-1:0]     out_filt_reg;

    logic [EST_W-1:0]   meas_q;
    logic [EST_W-1:0]   est_rd;
    logic [COV_W-1:0]   cov_rd;
    logic               started_rd;
    logic [DENOM_W-1:0] pred_sum;
    logic [REM_W-1:0]   rem_eff;
    logic [REM_W:0]     trial;
    logic               quo_bit;
    logic [GAIN_W-1:0]  gain;
    logic [GAIN_W-1:0]  mul_a;
    logic [COV_W-1:0]   mul_b;
    logic [PROD_W-1:0]  prod_ceil;

    assign meas_q = {meas_reg, {FRAC_W{1'b0}}};

    // Select the addressed channel's state
    always_comb begin
        est_rd     = '0;
        cov_rd     = '0;
        started_rd = 1'b0;
        for (int i = 0; i < CHANNELS; i++) begin
            if (int'(ch_reg) == i) begin
                est_rd     = est_mem_reg[i];
                cov_rd     = cov_mem_reg[i];
                started_rd = started_reg[i];
            end
        end
    end

    // Predicted covariance, saturated to 32 bits
    assign pred_sum = {1'b0, cov_rd} + DENOM_W'(process_noise);

    // One restoring divider step; the first step takes the remainder unshifted
    assign rem_eff = (cnt_reg == '0) ? rem_reg : {rem_reg[REM_W-2:0], 1'b0};
    assign trial   = {1'b0, rem_eff} - {2'b00, denom_reg};
    assign quo_bit = !trial[REM_W];
    assign status.div_last = (cnt_reg == DIV_CNT_W'(GAIN_W - 1));

    // Zero divisor gives zero gain
    assign gain = (denom_reg == '0) ? '0 : quo_reg;

    // Shared multiplier: gain * innovation, then (1 - gain) * predicted
    assign mul_a     = cmd.mul_cov ? (GAIN_ONE - gain) : gain;
    assign mul_b     = cmd.mul_cov ? pred_reg : COV_W'(diff_reg);
    assign prod_ceil = prod_reg + PROD_W'({FRAC_W{1'b1}});

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            ch_reg   <= s_tuser;
            meas_reg <= s_meas[MEAS_W-1:0];
        end
        if (cmd.prep) begin
            est_reg  <= started_rd ? est_rd : meas_q;
            pred_reg <= pred_sum[COV_W] ? {COV_W{1'b1}} : pred_sum[COV_W-1:0];
        end
        if (cmd.dinit) begin
            denom_reg <= {1'b0, pred_reg} + DENOM_W'(measure_noise);
            rem_reg   <= REM_W'(pred_reg);
            cnt_reg   <= '0;
            ge_reg    <= (meas_q >= est_reg);
            diff_reg  <= (meas_q >= est_reg) ? (meas_q - est_reg) : (est_reg - meas_q);
        end
        if (cmd.div_step) begin
            rem_reg <= quo_bit ? trial[REM_W-1:0] : rem_eff;
            quo_reg <= {quo_reg[GAIN_W-2:0], quo_bit};
            cnt_reg <= cnt_reg + 1'b1;
        end
        if (cmd.mul_gain || cmd.mul_cov) begin
            prod_reg <= mul_a * mul_b;
        end
        // Move the estimate: floor when rising, ceiling of the step when falling
        if (cmd.mul_cov) begin
            if (ge_reg) begin
                est_reg <= est_reg + prod_reg[FRAC_W +: EST_W];
            end else begin
                est_reg <= est_reg - prod_ceil[FRAC_W +: EST_W];
            end
        end
        if (cmd.out_load) begin
            out_ch_reg   <= ch_reg;
            out_filt_reg <= OUT_W'(est_reg[EST_W-1:FRAC_W]);
        end
    end

    // Write back channel state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            started_reg <= '0;
            for (int i = 0; i < CHANNELS; i++) begin
                est_mem_reg[i] <= '0;
                cov_mem_reg[i] <= '0;
            end
        end else if (cmd.commit) begin
            for (int i = 0; i < CHANNELS; i++) begin
                if (int'(ch_reg) == i) begin
                    est_mem_reg[i] <= est_reg;
                    cov_mem_reg[i] <= prod_reg[FRAC_W +: COV_W];
                    started_reg[i] <= 1'b1;
                end
            end
        end
    end

    assign m_tuser    = out_ch_reg;
    assign m_filtered = out_filt_reg;

endmodule

// ===== src/scalar_kalman_smoother.sv =====
// Scalar Kalman smoother for several distance sensor channels.
// Input beat: s_tdata carries the sample, s_tuser the channel number.
// Output beat: m_tdata carries the filtered distance, m_tuser the channel.
// Q and R are written through the APB port at byte addresses 0 and 4.
// Each channel keeps its own estimate, covariance and started flag; the
// first sample of a channel loads the estimate directly.
// Each sample passes through prepare, the 17-step restoring divider
// that forms the gain, two multiplies on one shared multiplier and the
// write back before its output goes valid. The block takes no new
// sample until it is done with the last one; s_tready is high only while idle.
// A beat with a channel number at or above CHANNELS is taken and
// dropped, with no result.
// The result sits in an output register; when the receiver stalls the
// block can still take one more sample and holds its result until the
// register frees up.
// Reset clears all channel state (not started) and loads Q = 1180 and
// R = 32768 (both Q8.16); m_tvalid drops.
module scalar_kalman_smoother #(
    parameter int CHANNELS     = 3,
    parameter int SAMPLE_WIDTH = 16
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    // Input stream
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [15:0]                   s_tdata,   // [15:0] measurement
    input  logic [1:0]                    s_tuser,   // [1:0] channel
    // Result stream
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [15:0]                   m_tdata,   // [15:0] filtered
    output logic [1:0]                    m_tuser,   // [1:0] result_channel
    // Configuration
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [ksm_pkg::PADDR_W-1:0]   paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);
    import ksm_pkg::*;

    logic [NOISE_W-1:0] process_noise_reg;
    logic [NOISE_W-1:0] measure_noise_reg;
    logic               cfg_write;
    ksm_cmd_t           cmd;
    ksm_status_t        status;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            process_noise_reg <= PROCESS_NOISE_RST;
            measure_noise_reg <= MEASURE_NOISE_RST;
        end else if (cfg_write) begin
            unique case (paddr[2])
                REG_IDX_PROCESS_NOISE: process_noise_reg <= pwdata[NOISE_W-1:0];
                REG_IDX_MEASURE_NOISE: measure_noise_reg <= pwdata[NOISE_W-1:0];
                default: ;
            endcase
        end
    end

    // Register readback
    always_comb begin
        unique case (paddr[2])
            REG_IDX_PROCESS_NOISE: prdata = 32'(process_noise_reg);
            REG_IDX_MEASURE_NOISE: prdata = 32'(measure_noise_reg);
            default:               prdata = '0;
        endcase
    end

    ksm_ctrl #(
        .CHANNELS (CHANNELS)
    ) u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd),
        .status   (status)
    );

    ksm_dp #(
        .CHANNELS     (CHANNELS),
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_dp (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd           (cmd),
        .status        (status),
        .s_tuser       (s_tuser),
        .s_meas        (s_tdata),
        .process_noise (process_noise_reg),
        .measure_noise (measure_noise_reg),
        .m_tuser       (m_tuser),
        .m_filtered    (m_tdata)
    );

endmodule

// ===== src/ksm_port_checker.sv =====
// Port-level checks for the scalar Kalman smoother, bound to the top level.
// Sees only the top level's ports; depends on nothing else.
module ksm_port_checker #(
    parameter int CHANNELS = 3
) (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [1:0]  s_tuser,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata,
    input logic [1:0]  m_tuser
);

    // Reset drops the result valid
    a_reset_clears_valid: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("m_tvalid high after reset");

    // A stalled result beat holds
    a_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result beat changed while stalled");

    // Results only name channels that exist
    a_channel_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> int'(m_tuser) < CHANNELS)
        else $error("result for a channel out of range");

    // A valid sample keeps the block busy the next cycle
    a_busy_after_sample: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && (int'(s_tuser) < CHANNELS) |=> !s_tready)
        else $error("input ready right after a valid sample");

endmodule

bind scalar_kalman_smoother ksm_port_checker #(
    .CHANNELS (CHANNELS)
) u_port_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
